FILE: rtl/lpmd_pkg.sv
`timescale 1ns / 1ps

package lpmd_pkg;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_MALFORMED = 2'd2,
        KIND_OVERSIZE  = 2'd3
    } kind_t;

    // one result word as it leaves the block
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [7:0]  msg_type;
        logic [7:0]  msg_flags;
        logic [15:0] channel;
        logic        last;
    } res_t;

    localparam logic [31:0] MAX_BLOCK_SIZE_RESET = 32'd1048576;
    localparam logic [1:0]  HEADER_LAST_INDEX    = 2'd3;

endpackage

FILE: rtl/lpmd_frame.sv
`timescale 1ns / 1ps

module lpmd_frame #(
    parameter int LENGTH_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        max_block_size,
    input  logic               step,
    input  logic [7:0]         stream_byte,
    output logic               res_valid,
    output lpmd_pkg::res_t     res
);

    localparam int PREFIX_BYTES = (LENGTH_BITS + 7) / 8;
    localparam logic [1:0] PREFIX_LAST = 2'(PREFIX_BYTES - 1);

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_HEADER,
        PH_PAYLOAD,
        PH_HALTED
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             field_index_reg, field_index_next;
    logic [LENGTH_BITS-1:0] length_accum_reg, length_accum_next;
    logic [LENGTH_BITS-1:0] body_left_reg, body_left_next;
    logic [7:0]             held_type_reg, held_type_next;
    logic [7:0]             held_flags_reg, held_flags_next;
    logic [15:0]            held_channel_reg, held_channel_next;

    logic [LENGTH_BITS+7:0] acc_wide;
    logic [LENGTH_BITS-1:0] acc;
    logic [LENGTH_BITS-1:0] body_dec;
    logic                   body_done;

    always_comb
    begin
        acc_wide  = {length_accum_reg, stream_byte};
        acc       = acc_wide[LENGTH_BITS-1:0];
        body_dec  = body_left_reg - LENGTH_BITS'(1);
        body_done = (body_left_reg == LENGTH_BITS'(1));

        phase_next        = phase_reg;
        field_index_next  = field_index_reg;
        length_accum_next = length_accum_reg;
        body_left_next    = body_left_reg;
        held_type_next    = held_type_reg;
        held_flags_next   = held_flags_reg;
        held_channel_next = held_channel_reg;

        res_valid     = 1'b0;
        res           = '0;
        res.kind      = lpmd_pkg::KIND_PAYLOAD;

        if (step)
        begin
            case (phase_reg)
                PH_LENGTH:
                begin
                    length_accum_next = acc;
                    if (field_index_reg != PREFIX_LAST)
                    begin
                        field_index_next = field_index_reg + 2'd1;
                    end
                    else
                    begin
                        field_index_next = 2'd0;
                        if (32'(acc) > max_block_size)
                        begin
                            phase_next = PH_HALTED;
                            res_valid  = 1'b1;
                            res.kind   = lpmd_pkg::KIND_OVERSIZE;
                            res.last   = 1'b1;
                        end
                        else
                        begin
                            body_left_next    = acc;
                            length_accum_next = '0;
                            if (acc == '0)
                            begin
                                res_valid = 1'b1;
                                res.kind  = lpmd_pkg::KIND_MALFORMED;
                                res.last  = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_HEADER;
                            end
                        end
                    end
                end
                PH_HEADER:
                begin
                    case (field_index_reg)
                        2'd0:    held_type_next  = stream_byte;
                        2'd1:    held_flags_next = stream_byte;
                        2'd2:    held_channel_next = {stream_byte, held_channel_reg[7:0]};
                        default: held_channel_next = {held_channel_reg[15:8], stream_byte};
                    endcase
                    body_left_next = body_dec;
                    if (body_done)
                    begin
                        phase_next       = PH_LENGTH;
                        field_index_next = 2'd0;
                        res_valid        = 1'b1;
                        res.last         = 1'b1;
                        if (field_index_reg == lpmd_pkg::HEADER_LAST_INDEX)
                        begin
                            res.kind      = lpmd_pkg::KIND_EMPTY;
                            res.msg_type  = held_type_reg;
                            res.msg_flags = held_flags_reg;
                            res.channel   = {held_channel_reg[15:8], stream_byte};
                        end
                        else
                        begin
                            res.kind = lpmd_pkg::KIND_MALFORMED;
                        end
                    end
                    else if (field_index_reg == lpmd_pkg::HEADER_LAST_INDEX)
                    begin
                        field_index_next = 2'd0;
                        phase_next       = PH_PAYLOAD;
                    end
                    else
                    begin
                        field_index_next = field_index_reg + 2'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    body_left_next = body_dec;
                    res_valid      = 1'b1;
                    res.kind       = lpmd_pkg::KIND_PAYLOAD;
                    res.data       = stream_byte;
                    res.msg_type   = held_type_reg;
                    res.msg_flags  = held_flags_reg;
                    res.channel    = held_channel_reg;
                    res.last       = body_done;
                    if (body_done)
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
                default:
                begin
                    // halted: bytes are swallowed until reset
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LENGTH;
            field_index_reg  <= 2'd0;
            length_accum_reg <= '0;
            body_left_reg    <= '0;
            held_type_reg    <= 8'd0;
            held_flags_reg   <= 8'd0;
            held_channel_reg <= 16'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            field_index_reg  <= field_index_next;
            length_accum_reg <= length_accum_next;
            body_left_reg    <= body_left_next;
            held_type_reg    <= held_type_next;
            held_flags_reg   <= held_flags_next;
            held_channel_reg <= held_channel_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALTED |=> phase_reg == PH_HALTED)
        else $error("left halted phase without reset");

    a_oversize_halts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == lpmd_pkg::KIND_OVERSIZE |=> phase_reg == PH_HALTED)
        else $error("oversize word did not halt the deframer");

    a_non_payload_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind != lpmd_pkg::KIND_PAYLOAD |-> res.last)
        else $error("status word without last");
`endif

endmodule

FILE: rtl/lpmd_obuf.sv
`timescale 1ns / 1ps

module lpmd_obuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lpmd_pkg::res_t push_res,
    output logic           room,
    output logic           out_valid,
    input  logic           out_stall,
    output lpmd_pkg::res_t out_res
);

    logic [1:0]     count_reg, count_next;
    lpmd_pkg::res_t head_reg, head_next;
    lpmd_pkg::res_t skid_reg, skid_next;
    logic           pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_res   = head_reg;
    assign room      = (count_reg != 2'd2);
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        head_next  = head_reg;
        skid_next  = skid_reg;
        if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                head_next = skid_reg;
            end
            else
            begin
                head_next = push_res;
            end
        end
        else if (count_reg == 2'd0)
        begin
            head_next = push_res;
        end
        if (push && !pop && count_reg == 2'd1)
        begin
            skid_next = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && count_reg == 2'd2))
        else $error("write into full result buffer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_res))
        else $error("result word changed while stalled");
`endif

endmodule

FILE: rtl/length_prefixed_message_deframer.sv
`timescale 1ns / 1ps

// channel   dir  handshake             word
// in        in   in_valid / in_stall   stream_byte
// out       out  out_valid / out_stall kind, data, msg_type, msg_flags, channel, last
// cfg       in   cfg_wr_en             cfg_wr_data (max_block_size)
//
// one word per cycle in, one result per cycle out, sustained while out_stall stays low
// a word is held in the input register, then the frame logic writes its
// result (if any) into a two-entry output buffer, which drives out_valid
// in_stall rises only when the input register holds a word and the output buffer is full
// reset clears framing state, buffer and max_block_size (1048576); no clearing pass
// after an oversize length every word is dropped until reset

module length_prefixed_message_deframer #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  data,
    output logic [7:0]  msg_type,
    output logic [7:0]  msg_flags,
    output logic [15:0] channel,
    output logic        last
);

    // configuration register
    logic [31:0] max_block_size_reg;

    // input register stage
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_accept;

    // frame step and result path
    logic           room;
    logic           step;
    logic           res_valid;
    lpmd_pkg::res_t res;
    lpmd_pkg::res_t out_res;

    // the input register moves on whenever the buffer has a free entry
    assign step      = in_valid_reg && room;
    assign in_stall  = in_valid_reg && !room;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_block_size_reg <= lpmd_pkg::MAX_BLOCK_SIZE_RESET;
            in_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_block_size_reg <= cfg_wr_data;
            end
            in_valid_reg <= in_valid_next;
        end
    end

    // byte holds while stalled, loads on accept
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= stream_byte;
        end
    end

    lpmd_frame #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_frame (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_block_size (max_block_size_reg),
        .step           (step),
        .stream_byte    (in_byte_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    lpmd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    // unpack the result word onto its ports
    assign kind      = out_res.kind;
    assign data      = out_res.data;
    assign msg_type  = out_res.msg_type;
    assign msg_flags = out_res.msg_flags;
    assign channel   = out_res.channel;
    assign last      = out_res.last;

endmodule

FILE: tb/length_prefixed_message_deframer_test.sv
`timescale 1ns / 1ps

module length_prefixed_message_deframer_test;

    localparam int          LENGTH_BITS    = 32;
    localparam int          PREFIX_BYTES   = (LENGTH_BITS + 7) / 8;
    localparam logic [63:0] LENGTH_MASK    = (64'd1 << LENGTH_BITS) - 64'd1;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          RANDOM_FILL    = -1;

    // where the predictor stands inside the current block
    typedef enum logic [1:0] {
        AWAIT_LENGTH,
        AWAIT_HEADER,
        IN_PAYLOAD,
        HALTED
    } frame_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  stream_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  msg_type;
    logic [7:0]  msg_flags;
    logic [15:0] channel;
    logic        last;

    length_prefixed_message_deframer #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .stream_byte(stream_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .data       (data),
        .msg_type   (msg_type),
        .msg_flags  (msg_flags),
        .channel    (channel),
        .last       (last)
    );

    // stream words waiting for the driver, results waiting for the monitor
    logic [7:0]     pending_bytes[$];
    lpmd_pkg::res_t expected_results[$];
    int unsigned    queued_count = 0;
    int unsigned    error_count = 0;
    int unsigned    idle_cycles = 0;
    int unsigned    send_gap = 0;
    int unsigned    stall_left = 0;
    bit             steady = 1'b0;

    // predictor state, mirrors the block after reset
    logic [31:0]  size_limit = lpmd_pkg::MAX_BLOCK_SIZE_RESET;
    frame_phase_t frame_phase = AWAIT_LENGTH;
    logic [1:0]   field_pos = 2'd0;
    logic [31:0]  length_acc = 32'd0;
    logic [31:0]  body_remaining = 32'd0;
    logic [7:0]   hdr_type = 8'd0;
    logic [7:0]   hdr_flags = 8'd0;
    logic [15:0]  hdr_channel = 16'd0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones, none at all in steady stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
        error_count++;
    endtask

    // advance the frame state by one accepted word, queue the result it causes
    function automatic void deframe_byte(input logic [7:0] b);
        lpmd_pkg::res_t r;
        logic [63:0]    acc;
        bit             fresh;
        r = '0;
        fresh = 1'b0;
        case (frame_phase)
            AWAIT_LENGTH:
            begin
                // big-endian prefix, kept to LENGTH_BITS
                acc = (({32'd0, length_acc} << 8) | {56'd0, b}) & LENGTH_MASK;
                length_acc = acc[31:0];
                if (field_pos != 2'(PREFIX_BYTES - 1))
                begin
                    field_pos++;
                end
                else
                begin
                    field_pos = 2'd0;
                    if (length_acc > size_limit)
                    begin
                        // oversize: report once, then go deaf until reset
                        frame_phase = HALTED;
                        r.kind = lpmd_pkg::KIND_OVERSIZE;
                        r.last = 1'b1;
                        fresh = 1'b1;
                    end
                    else
                    begin
                        body_remaining = length_acc;
                        length_acc = 32'd0;
                        if (body_remaining == 32'd0)
                        begin
                            r.kind = lpmd_pkg::KIND_MALFORMED;
                            r.last = 1'b1;
                            fresh = 1'b1;
                        end
                        else
                        begin
                            frame_phase = AWAIT_HEADER;
                        end
                    end
                end
            end
            AWAIT_HEADER:
            begin
                case (field_pos)
                    2'd0:    hdr_type = b;
                    2'd1:    hdr_flags = b;
                    2'd2:    hdr_channel[15:8] = b;
                    default: hdr_channel[7:0] = b;
                endcase
                body_remaining--;
                if (body_remaining == 32'd0)
                begin
                    // body ends inside or right at the end of the header
                    frame_phase = AWAIT_LENGTH;
                    if (field_pos == lpmd_pkg::HEADER_LAST_INDEX)
                    begin
                        r.kind = lpmd_pkg::KIND_EMPTY;
                        r.msg_type = hdr_type;
                        r.msg_flags = hdr_flags;
                        r.channel = hdr_channel;
                    end
                    else
                    begin
                        r.kind = lpmd_pkg::KIND_MALFORMED;
                    end
                    r.last = 1'b1;
                    field_pos = 2'd0;
                    fresh = 1'b1;
                end
                else if (field_pos == lpmd_pkg::HEADER_LAST_INDEX)
                begin
                    field_pos = 2'd0;
                    frame_phase = IN_PAYLOAD;
                end
                else
                begin
                    field_pos++;
                end
            end
            IN_PAYLOAD:
            begin
                body_remaining--;
                r.kind = lpmd_pkg::KIND_PAYLOAD;
                r.data = b;
                r.msg_type = hdr_type;
                r.msg_flags = hdr_flags;
                r.channel = hdr_channel;
                r.last = (body_remaining == 32'd0);
                fresh = 1'b1;
                if (body_remaining == 32'd0)
                    frame_phase = AWAIT_LENGTH;
            end
            default:
            begin
            end
        endcase
        if (fresh)
            expected_results.push_back(r);
    endfunction

    // one block: prefix, header bytes as far as the body reaches, then payload
    task automatic queue_block(input int unsigned len, input logic [7:0] typ,
                               input logic [7:0] flg, input logic [15:0] ch,
                               input int fill);
        int i;
        for (i = PREFIX_BYTES - 1; i >= 0; i--)
            pending_bytes.push_back(8'(len >> (8 * i)));
        for (i = 0; i < int'(len); i++)
        begin
            case (i)
                0:       pending_bytes.push_back(typ);
                1:       pending_bytes.push_back(flg);
                2:       pending_bytes.push_back(ch[15:8]);
                3:       pending_bytes.push_back(ch[7:0]);
                default: pending_bytes.push_back(fill < 0 ? 8'($urandom_range(0, 255))
                                                          : 8'(fill));
            endcase
        end
        queued_count += PREFIX_BYTES + len;
    endtask

    // mostly well-formed blocks with random content, some empty or short
    task automatic queue_random_block(input int unsigned cap);
        int unsigned r;
        int unsigned len;
        r = $urandom_range(0, 99);
        if (r < 12)
            len = $urandom_range(0, 3);
        else if (r < 22)
            len = 4;
        else if (r < 92)
            len = $urandom_range(5, 16);
        else
            len = $urandom_range(17, 48);
        if (len > cap)
            len = $urandom_range(0, cap);
        queue_block(len, 8'($urandom), 8'($urandom), 16'($urandom), RANDOM_FILL);
    endtask

    // sender holds back until every expected result is in, then the block settles
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size_limit(input logic [31:0] value);
        wait_drained();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        size_limit = value;
    endtask

    task automatic run_random(input int unsigned cap, input int unsigned stop_at);
        while (queued_count < stop_at)
        begin
            // keep the driver fed without queueing the whole run at once
            while (pending_bytes.size() > 16)
                @(negedge clk);
            if ($urandom_range(0, 19) == 0)
                steady = !steady;
            if ($urandom_range(0, 24) == 0)
                wait_drained();
            queue_random_block(cap);
        end
    endtask

    // stimulus: directed blocks, then random phases under several size limits
    initial
    begin
        int unsigned cap;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset limit: zero length, short body, empty message, payload extremes
        queue_block(0, 8'h00, 8'h00, 16'h0000, RANDOM_FILL);
        queue_block(2, 8'hA5, 8'h5A, 16'h0000, RANDOM_FILL);
        queue_block(4, 8'hFF, 8'h00, 16'hFFFF, RANDOM_FILL);
        queue_block(6, 8'h00, 8'hFF, 16'h0000, 8'hFF);
        queue_block(5, 8'h81, 8'h7E, 16'h8001, 8'h00);

        // widest limit, long random stretch
        write_size_limit(32'hFFFF_FFFF);
        run_random(64, 350);

        // zero limit: only zero-length blocks pass the size check
        write_size_limit(32'd0);
        repeat (3)
            queue_block(0, 8'h00, 8'h00, 16'h0000, RANDOM_FILL);

        // small limit, a block of exactly that length first
        cap = $urandom_range(5, 40);
        write_size_limit(cap);
        queue_block(cap, 8'($urandom), 8'($urandom), 16'($urandom), RANDOM_FILL);
        run_random(cap, 620);

        // one over the limit: oversize error, trailing words are dropped
        wait_drained();
        queue_block(cap + 1, 8'h00, 8'h00, 16'h0000, RANDOM_FILL);

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // driver: presents the next word once the previous one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                deframe_byte(stream_byte);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    stream_byte <= pending_bytes.pop_front();
                    send_gap = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each taken result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin : check_result
                lpmd_pkg::res_t want;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing pending, kind", 32'd0, 32'(kind));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", 32'(want.kind), 32'(kind));
                    if (data !== want.data)
                        report_mismatch("data", 32'(want.data), 32'(data));
                    if (msg_type !== want.msg_type)
                        report_mismatch("msg_type", 32'(want.msg_type), 32'(msg_type));
                    if (msg_flags !== want.msg_flags)
                        report_mismatch("msg_flags", 32'(want.msg_flags), 32'(msg_flags));
                    if (channel !== want.channel)
                        report_mismatch("channel", 32'(want.channel), 32'(channel));
                    if (last !== want.last)
                        report_mismatch("last", 32'(want.last), 32'(last));
                end
            end
            // random stall bursts on the result side
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("timeout at %0t", $time);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

endmodule
